[sv/qcs_pkg.sv]
// qcs_pkg: shared types and constants for the quadrature counter with speed unit.
// No dependencies; imported by every module of the block but qcs_fifo.
package qcs_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef enum logic {
    REG_COUNTS_PER_REV  = 1'b0,
    REG_MIN_INTERVAL_MS = 1'b1
  } reg_index_t;

  // classified item handed from the front to the back
  typedef struct packed {
    cmd_t  op;
    step_t right_step;
    step_t left_step;
  } item_t;

  typedef struct packed {
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic signed [31:0] right_speed;
    logic signed [31:0] left_speed;
    logic               speed_updated;
  } result_t;

  typedef enum logic [2:0] {
    BK_RUN,
    BK_RIGHT,
    BK_RWAIT,
    BK_LEFT,
    BK_LWAIT,
    BK_FINISH
  } back_state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_MUL,
    SP_DIV,
    SP_FIN
  } spd_state_t;

  localparam int CFG_DATA_W       = 16;
  localparam int CPR_W            = 16;
  localparam int MIN_INTERVAL_W   = 10;
  localparam int ELAPSED_W        = 32;
  localparam int DEN_W            = CPR_W + ELAPSED_W;
  localparam int FRAC_SHIFT       = 16;
  localparam int SPEED_K_W        = 48;
  localparam int SPEED_K_CHUNK_W  = 16;
  localparam int SPEED_K_CHUNKS   = SPEED_K_W / SPEED_K_CHUNK_W;

  localparam logic [CPR_W-1:0]          CPR_RESET          = 16'd520;
  localparam logic [MIN_INTERVAL_W-1:0] MIN_INTERVAL_RESET = 10'd10;

  // 2*pi in Q32, scaled by 1000 for ms -> s
  localparam logic [SPEED_K_W-1:0] TWO_PI_Q32 = 48'h6_487E_D511;
  localparam logic [SPEED_K_W-1:0] SPEED_K    = TWO_PI_Q32 * 48'd1000;

endpackage

[sv/qcs_fifo.sv]
// qcs_fifo: small register-based first-in first-out queue.
// Standalone; used for the item queue and the result queue.
module qcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[sv/qcs_front.sv]
// qcs_front: accepts input transactions, detects A-line edges, queues classified items.
// Depends on qcs_pkg and qcs_fifo.
module qcs_front
  import qcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic       right_a,
  input  logic       right_b,
  input  logic       left_a,
  input  logic       left_b,
  input  logic       item_pop,
  output item_t      item,
  output logic       item_empty
);

  logic  right_a_last;
  logic  left_a_last;
  logic  accept;
  item_t item_in;
  logic [$bits(item_t)-1:0] item_raw;

  assign accept = push && !full;

  // A-last bits follow pin samples only, so edges are resolved here in order
  always_comb begin
    item_in.op         = cmd_t'(cmd);
    item_in.right_step = STEP_NONE;
    item_in.left_step  = STEP_NONE;
    if (cmd_t'(cmd) == CMD_SAMPLE) begin
      if (right_a != right_a_last) begin
        item_in.right_step = (right_a == right_b) ? STEP_UP : STEP_DOWN;
      end
      if (left_a != left_a_last) begin
        item_in.left_step = (left_a == left_b) ? STEP_UP : STEP_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_a_last <= 1'b0;
      left_a_last  <= 1'b0;
    end else if (accept && cmd_t'(cmd) == CMD_SAMPLE) begin
      right_a_last <= right_a;
      left_a_last  <= left_a;
    end
  end

  qcs_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(4)
  ) u_item_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (item_in),
    .full (full),
    .pop  (item_pop),
    .dout (item_raw),
    .empty(item_empty)
  );

  assign item = item_t'(item_raw);

endmodule

[sv/qcs_speed.sv]
// qcs_speed: multi-cycle speed unit, |delta|*K by 16-bit chunks then restoring divide.
// Depends on qcs_pkg. One channel per start; result held until the next start.
module qcs_speed
  import qcs_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] delta,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic signed [31:0]     speed
);

  localparam int PROD_W = COUNT_WIDTH + SPEED_K_W;
  localparam int NUM_W  = PROD_W - FRAC_SHIFT;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int KI_W   = $clog2(SPEED_K_CHUNKS);

  localparam logic [32:0] Q_CLAMP   = 33'h1_0000_0000;
  localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;

  spd_state_t state, state_next;

  logic                   neg;
  logic [COUNT_WIDTH-1:0] mag;
  logic [DEN_W-1:0]       den_r;
  logic [PROD_W-1:0]      prod;
  logic [DEN_W-1:0]       rem;
  logic [32:0]            quo;
  logic [KI_W-1:0]        k_idx;
  logic [CNT_W-1:0]       bit_cnt;

  logic [COUNT_WIDTH+SPEED_K_CHUNK_W-1:0] part;
  logic [DEN_W:0]  rem_t;
  logic            ge;
  logic [33:0]     quo_t;
  logic [32:0]     qm;
  logic [32:0]     neg_q;
  logic            last_chunk;

  assign last_chunk = (k_idx == KI_W'(SPEED_K_CHUNKS - 1));
  assign part  = mag * SPEED_K[k_idx*SPEED_K_CHUNK_W +: SPEED_K_CHUNK_W];
  assign rem_t = {rem, prod[PROD_W-1]};
  assign ge    = (rem_t >= {1'b0, den_r});
  assign quo_t = {quo, ge};

  always_comb begin
    state_next = state;
    case (state)
      SP_IDLE: if (start) state_next = SP_MUL;
      SP_MUL:  if (last_chunk) state_next = SP_DIV;
      SP_DIV:  if (bit_cnt == CNT_W'(1)) state_next = SP_FIN;
      SP_FIN:  state_next = SP_IDLE;
      default: state_next = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SP_IDLE: begin
        if (start) begin
          neg     <= delta[COUNT_WIDTH-1];
          mag     <= delta[COUNT_WIDTH-1] ? -delta : delta;
          den_r   <= den;
          prod    <= '0;
          rem     <= '0;
          quo     <= '0;
          k_idx   <= '0;
          bit_cnt <= CNT_W'(NUM_W);
        end
      end
      SP_MUL: begin
        prod  <= prod + (PROD_W'(part) << (k_idx * SPEED_K_CHUNK_W));
        k_idx <= k_idx + 1'b1;
      end
      SP_DIV: begin
        // numerator is prod without its low FRAC_SHIFT bits, taken MSB first
        rem     <= ge ? DEN_W'(rem_t - {1'b0, den_r}) : rem_t[DEN_W-1:0];
        quo     <= (quo_t > {1'b0, Q_CLAMP}) ? Q_CLAMP : quo_t[32:0];
        prod    <= prod << 1;
        bit_cnt <= bit_cnt - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    done  = (state == SP_FIN);
    qm    = (quo > NEG_LIMIT) ? NEG_LIMIT : quo;
    neg_q = ~qm + 33'd1;
    if (!neg) begin
      speed = (quo > POS_LIMIT) ? 32'sh7FFF_FFFF : signed'(quo[31:0]);
    end else begin
      speed = signed'(neg_q[31:0]);
    end
  end

endmodule

[sv/qcs_back.sv]
// qcs_back: executes queued items: positions, elapsed time, config, speed sequencing.
// Depends on qcs_pkg and qcs_speed.
module qcs_back
  import qcs_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  item_t                 item,
  input  logic                  item_empty,
  output logic                  item_pop,
  output result_t               res_data,
  output logic                  res_push,
  input  logic                  res_full
);

  back_state_t state, state_next;

  logic [COUNT_WIDTH-1:0]    right_pos, right_pos_next;
  logic [COUNT_WIDTH-1:0]    left_pos, left_pos_next;
  logic [COUNT_WIDTH-1:0]    right_prior, right_prior_next;
  logic [COUNT_WIDTH-1:0]    left_prior, left_prior_next;
  logic [ELAPSED_W-1:0]      elapsed, elapsed_next;
  logic signed [31:0]        right_speed, right_speed_next;
  logic signed [31:0]        left_speed, left_speed_next;
  logic [DEN_W-1:0]          den, den_next;
  logic [CPR_W-1:0]          cpr;
  logic [MIN_INTERVAL_W-1:0] min_interval;

  logic [CPR_W-1:0]          cpr_eff;
  logic [MIN_INTERVAL_W-1:0] min_eff;
  logic [DEN_W-1:0]          den_prod;
  logic                      upd_ok;
  logic                      go;
  logic                      run_update;
  logic                      spd_start;
  logic                      spd_done;
  logic signed [31:0]        spd_speed;
  logic [COUNT_WIDTH-1:0]    spd_delta;

  assign cpr_eff    = (cpr == '0) ? CPR_W'(1) : cpr;
  assign min_eff    = (min_interval == '0) ? MIN_INTERVAL_W'(1) : min_interval;
  assign den_prod   = cpr_eff * elapsed;
  assign upd_ok     = (elapsed >= ELAPSED_W'(min_eff));
  assign go         = !item_empty && !res_full;
  assign run_update = go && item.op == CMD_UPDATE && upd_ok;
  assign spd_delta  = (state == BK_LEFT) ? left_pos - left_prior : right_pos - right_prior;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_RUN:    if (run_update) state_next = BK_RIGHT;
      BK_RIGHT:  state_next = BK_RWAIT;
      BK_RWAIT:  if (spd_done) state_next = BK_LEFT;
      BK_LEFT:   state_next = BK_LWAIT;
      BK_LWAIT:  if (spd_done) state_next = BK_FINISH;
      BK_FINISH: if (!res_full) state_next = BK_RUN;
      default:   state_next = BK_RUN;
    endcase
  end

  // handshake outputs
  always_comb begin
    item_pop  = 1'b0;
    res_push  = 1'b0;
    spd_start = 1'b0;
    case (state)
      BK_RUN: begin
        item_pop = go;
        res_push = go && !run_update;
      end
      BK_RIGHT, BK_LEFT: spd_start = 1'b1;
      BK_FINISH:         res_push  = !res_full;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    right_pos_next   = right_pos;
    left_pos_next    = left_pos;
    right_prior_next = right_prior;
    left_prior_next  = left_prior;
    elapsed_next     = elapsed;
    right_speed_next = right_speed;
    left_speed_next  = left_speed;
    den_next         = den;
    case (state)
      BK_RUN: begin
        if (go) begin
          case (item.op)
            CMD_SAMPLE: begin
              if (item.right_step == STEP_UP) begin
                right_pos_next = right_pos + 1'b1;
              end else if (item.right_step == STEP_DOWN) begin
                right_pos_next = right_pos - 1'b1;
              end
              if (item.left_step == STEP_UP) begin
                left_pos_next = left_pos + 1'b1;
              end else if (item.left_step == STEP_DOWN) begin
                left_pos_next = left_pos - 1'b1;
              end
            end
            CMD_TICK: begin
              if (elapsed != '1) begin
                elapsed_next = elapsed + 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (upd_ok) begin
                den_next = den_prod;
              end
            end
            CMD_CLEAR: begin
              right_pos_next = '0;
              left_pos_next  = '0;
            end
            default: ;
          endcase
        end
      end
      BK_RWAIT: if (spd_done) right_speed_next = spd_speed;
      BK_LWAIT: if (spd_done) left_speed_next = spd_speed;
      BK_FINISH: begin
        if (!res_full) begin
          right_prior_next = right_pos;
          left_prior_next  = left_pos;
          elapsed_next     = '0;
        end
      end
      default: ;
    endcase

    // size cast sign-extends narrow counts and keeps the low bits of wide ones
    res_data.right_count   = 32'(signed'(right_pos_next));
    res_data.left_count    = 32'(signed'(left_pos_next));
    res_data.right_speed   = right_speed;
    res_data.left_speed    = left_speed;
    res_data.speed_updated = (state == BK_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_RUN;
      right_pos    <= '0;
      left_pos     <= '0;
      right_prior  <= '0;
      left_prior   <= '0;
      elapsed      <= '0;
      right_speed  <= '0;
      left_speed   <= '0;
      cpr          <= CPR_RESET;
      min_interval <= MIN_INTERVAL_RESET;
    end else begin
      state       <= state_next;
      right_pos   <= right_pos_next;
      left_pos    <= left_pos_next;
      right_prior <= right_prior_next;
      left_prior  <= left_prior_next;
      elapsed     <= elapsed_next;
      right_speed <= right_speed_next;
      left_speed  <= left_speed_next;
      if (cfg_we) begin
        case (reg_index_t'(cfg_addr))
          REG_COUNTS_PER_REV:  cpr          <= cfg_wdata;
          REG_MIN_INTERVAL_MS: min_interval <= cfg_wdata[MIN_INTERVAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    den <= den_next;
  end

  qcs_speed #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_speed (
    .clk  (clk),
    .rst  (rst),
    .start(spd_start),
    .delta(spd_delta),
    .den  (den),
    .done (spd_done),
    .speed(spd_speed)
  );

endmodule

[sv/quadrature_counter_with_speed_unit.sv]
// Top level of the two-channel quadrature counter with speed estimate.
// Depends on qcs_pkg, qcs_front, qcs_back and qcs_fifo.
//
// Items enter through a 4-deep queue (push/full) where pin samples are turned into
// up/down steps per channel; results leave through a 2-deep queue (empty/pop), one
// result per item. Pin samples, ms ticks, clears and updates that come too early
// are handled directly in the back end's run state, so a steady stream runs at one
// item per cycle while the result queue has room. An update that recomputes the
// speeds runs both channels in turn through one shared unit (three 16-bit
// partial-product steps, then one quotient bit per cycle over COUNT_WIDTH+32
// bits); items queue up behind it. Speeds are Q15.16 rad/s, rounded toward zero
// and saturated. Config writes (cfg_we) apply at the next edge.
module quadrature_counter_with_speed_unit
  import qcs_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            cmd,
  input  logic                  right_a,
  input  logic                  right_b,
  input  logic                  left_a,
  input  logic                  left_b,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [31:0]    right_count,
  output logic signed [31:0]    left_count,
  output logic signed [31:0]    right_speed,
  output logic signed [31:0]    left_speed,
  output logic                  speed_updated,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  item_t   item;
  logic    item_empty;
  logic    item_pop;
  result_t res_data;
  logic    res_push;
  logic    res_full;
  result_t res_out;
  logic [$bits(result_t)-1:0] res_raw;

  qcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .right_a   (right_a),
    .right_b   (right_b),
    .left_a    (left_a),
    .left_b    (left_b),
    .item_pop  (item_pop),
    .item      (item),
    .item_empty(item_empty)
  );

  qcs_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .item_empty(item_empty),
    .item_pop  (item_pop),
    .res_data  (res_data),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  qcs_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .full (res_full),
    .pop  (pop),
    .dout (res_raw),
    .empty(empty)
  );

  assign res_out       = result_t'(res_raw);
  assign right_count   = res_out.right_count;
  assign left_count    = res_out.left_count;
  assign right_speed   = res_out.right_speed;
  assign left_speed    = res_out.left_speed;
  assign speed_updated = res_out.speed_updated;

  // back end never writes a result into a full queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into full result queue");

  // back end never takes an item from an empty queue
  a_no_item_underflow: assert property (@(posedge clk) disable iff (rst)
    !(item_pop && item_empty))
    else $error("item popped from empty item queue");

  // every non-update item yields its result in the cycle it is taken
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (item_pop && item.op != CMD_UPDATE) |-> (res_push && !res_data.speed_updated))
    else $error("item taken without its transaction result");

  // a recomputed-speed result ends an update and is not paired with a new item
  a_update_finish: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.speed_updated) |-> !item_pop)
    else $error("speed result overlaps an item pop");

endmodule
